// File: hw/rtl/assert_macros.svh
// Assertion macros used by the controller RTL of the block allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication check, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication check, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/bffa_pkg.sv
// Package with the types, constants and codes of the block allocator.
package bffa_pkg;
   localparam int unsigned NUM_BLOCKS = 4096;
   localparam int unsigned MAP_WORDS = (NUM_BLOCKS + 31) / 32;
   localparam int unsigned WIDX_W = $clog2(MAP_WORDS);
   localparam int unsigned BLK_W = $clog2(NUM_BLOCKS);
   localparam int unsigned CNT_W = 13;
   localparam int unsigned ADDR_W = 32;
   localparam int unsigned BLOCK_SHIFT = 12;
   localparam logic [ADDR_W-1:0] BASE_RESET = 32'hA000_0000;
   localparam logic [ADDR_W:0] NUM_BLOCKS_EXT = (ADDR_W+1)'(NUM_BLOCKS);

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE = 2'd1;
   localparam logic [1:0] CMD_REPORT = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture request fields
      logic scan_start; // clear scan position and run length
      logic scan_step;  // consume one map word (read data valid)
      logic rd_en;      // issue map read at rd_addr
      logic [WIDX_W-1:0] rd_addr;
      logic mark_start; // load mark cursor (alloc or free)
      logic mark_step;  // apply mask to word read back
      logic mark_set;   // 1 sets bits, 0 clears bits
      logic finish;     // build result
      logic [1:0] res_status;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic found;      // a run is complete
      logic scan_last;  // scan consumed the last word
      logic mark_last;  // current mark word is the final one
      logic free_bad;   // free request out of range
      logic cnt_zero;   // block count is zero
      logic cnt_over;   // block count above map size
      logic [WIDX_W-1:0] mark_word; // word index for the mark pass
   } stat_type;
endpackage

// File: hw/rtl/bitmap_first_fit_block_allocator.sv
// Top level of the bitmap first-fit block allocator.
// The block manages NUM_BLOCKS blocks of 4 KiB; block zero sits at the base address
// held in the register that the csr_ channel writes.
// Requests arrive on the req_ channel; one transfer carries req_command,
// req_block_count and req_free_address and is taken at a rising edge with req_valid
// high and req_stall low. Each request yields exactly one result transfer on the
// rsp_ channel, held stable while rsp_stall is high.
// Only one request is in flight: req_stall stays high from acceptance until the cycle
// after its result transfer, so a stalled receiver also holds off the sender.
// Sequence after acceptance: a report, a failed count check or a rejected free passes
// through S_DECIDE and S_DONE to the result in S_OUT, and the next request can be
// taken in the cycle after the result transfer. An allocate scans the map one 32-bit
// word per cycle and stops in the cycle after it consumes the word that completes the
// run, or all MAP_WORDS words; it then marks the run word by word, reading each touched
// word in S_MARK_RD and writing it in S_MARK_WR. A free runs the marking pass only.
// After reset the map memory is cleared one word per cycle, through all MAP_WORDS
// words, while req_stall is high; the used count starts at zero and the base register
// at 0xA0000000. csr_ready is high while no request is in flight.
module bitmap_first_fit_block_allocator (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_command,
   input  logic [12:0] req_block_count,
   input  logic [31:0] req_free_address,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [31:0] rsp_result_address,
   output logic [1:0] rsp_status,
   output logic [12:0] rsp_used_blocks,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [31:0] csr_base_address
);
   import bffa_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   logic idle;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [1:0] cmd_hold;

   // The map memory is cleared by a sweep after reset; requests wait.
   logic [WIDX_W:0] clr_ff, clr_in;
   logic clearing;
   ctrl_type ctrl_dp;

   assign clearing = !clr_ff[WIDX_W];
   assign clr_in = clearing ? clr_ff + 1'b1 : clr_ff;

   always_comb begin
      base_in = base_ff;
      if (csr_valid && csr_ready) begin
         base_in = csr_base_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
         clr_ff <= '0;
      end else begin
         base_ff <= base_in;
         clr_ff <= clr_in;
      end
   end

   // The base register only changes while the controller waits for a request.
   assign csr_ready = idle;
   assign cmd_hold = req_command;

   logic req_valid_g;
   logic req_stall_c;
   assign req_valid_g = req_valid && !clearing;
   assign req_stall = req_stall_c || clearing;

   bffa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid_g),
      .req_stall  (req_stall_c),
      .req_command(cmd_hold),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .ctrl       (ctrl),
      .idle       (idle)
   );

   // During the clearing sweep the datapath writes a zero word at each address
   // in turn and receives no commands.
   always_comb begin
      ctrl_dp = ctrl;
      if (clearing) begin
         ctrl_dp = '0;
      end
   end

   logic [31:0] res_address;
   logic [1:0] res_status;
   logic [12:0] res_used;
   logic [1:0] cmd_q_ff, cmd_q_in;
   assign cmd_q_in = (req_valid_g && !req_stall_c) ? req_command : cmd_q_ff;
   always_ff @(posedge clock) begin
      cmd_q_ff <= cmd_q_in;
   end

   bffa_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .clearing        (clearing),
      .clr_word        (clr_ff[WIDX_W-1:0]),
      .ctrl            (ctrl_dp),
      .stat            (stat),
      .req_command     (cmd_q_ff),
      .req_block_count (req_block_count),
      .req_free_address(req_free_address),
      .base_address    (base_ff),
      .res_address     (res_address),
      .res_status      (res_status),
      .res_used        (res_used)
   );

   assign rsp_result_address = res_address;
   assign rsp_status = res_status;
   assign rsp_used_blocks = res_used;
endmodule

// File: hw/rtl/bffa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module bffa_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/bffa_datapath.sv
// Datapath of the block allocator: bitmap memory, run search and marking.
module bffa_datapath (
   input  logic clock,
   input  logic reset,
   input  logic clearing,
   input  logic [bffa_pkg::WIDX_W-1:0] clr_word,
   input  bffa_pkg::ctrl_type ctrl,
   output bffa_pkg::stat_type stat,
   input  logic [1:0] req_command,
   input  logic [12:0] req_block_count,
   input  logic [31:0] req_free_address,
   input  logic [31:0] base_address,
   output logic [31:0] res_address,
   output logic [1:0] res_status,
   output logic [12:0] res_used
);
   import bffa_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] faddr_ff, faddr_in;
   logic [BLK_W:0] run_ff, run_in;        // current free run length
   logic [BLK_W:0] bpos_ff, bpos_in;      // blocks consumed by scan
   logic [BLK_W:0] start_ff, start_in;    // run start for marking
   logic [BLK_W:0] mfirst_ff, mfirst_in;  // first block to mark
   logic [BLK_W:0] mend_ff, mend_in;      // one past last block to mark
   logic [WIDX_W:0] mword_ff, mword_in;   // mark cursor word
   logic found_ff, found_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [ADDR_W-1:0] raddr_ff, raddr_in;
   logic [1:0] rstat_ff, rstat_in;
   logic [31:0] rd_data;
   logic wr_en;
   logic [WIDX_W-1:0] wr_addr;
   logic [31:0] wr_data;
   logic [ADDR_W-1:0] offset;
   logic [ADDR_W-BLOCK_SHIFT-1:0] fstart;
   logic [ADDR_W:0] fend;
   logic [5:0] chg;
   logic [31:0] mask;
   logic [BLK_W:0] wlo;

   bffa_ram #(.WIDTH(32), .DEPTH(MAP_WORDS)) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (ctrl.rd_en),
      .rd_addr(ctrl.rd_addr),
      .rd_data(rd_data)
   );

   assign offset = faddr_ff - base_address;
   assign fstart = offset[ADDR_W-1:BLOCK_SHIFT];
   assign fend = (ADDR_W+1)'(fstart) + (ADDR_W+1)'(cnt_ff);
   assign wlo = {mword_ff, 5'd0};

   // Mask of bits in the current mark word that fall inside [mfirst, mend).
   // The clearing sweep after reset writes zero words instead.
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         mask[i] = ((wlo + (BLK_W+1)'(i)) >= mfirst_ff) &&
                   ((wlo + (BLK_W+1)'(i)) < mend_ff);
      end
      if (ctrl.mark_set) begin
         wr_data = rd_data | mask;
         chg = 6'($countones(mask & ~rd_data));
      end else begin
         wr_data = rd_data & ~mask;
         chg = 6'($countones(mask & rd_data));
      end
      if (clearing) begin
         wr_data = '0;
      end
   end
   assign wr_en = clearing || ctrl.mark_step;
   assign wr_addr = clearing ? clr_word : mword_ff[WIDX_W-1:0];

   // Run search over one map word per cycle. Each bit position takes its run
   // length from the last used bit at or below it in the word, or from the carried
   // run when the word is free up to there; the lowest position whose run
   // reaches the count ends the search.
   always_comb begin
      logic [BLK_W:0] r;
      logic f;
      logic [BLK_W:0] s;
      logic any;
      logic [4:0] p;
      logic [4:0] hit;
      logic [BLK_W:0] len;
      r = run_ff;
      f = found_ff;
      s = start_ff;
      any = 1'b0;
      p = '0;
      hit = '0;
      len = run_ff;
      cnt_in = cnt_ff;
      faddr_in = faddr_ff;
      bpos_in = bpos_ff;
      mfirst_in = mfirst_ff;
      mend_in = mend_ff;
      mword_in = mword_ff;
      used_in = used_ff;
      raddr_in = raddr_ff;
      rstat_in = rstat_ff;
      if (ctrl.load) begin
         cnt_in = req_block_count;
         faddr_in = req_free_address;
      end
      if (ctrl.scan_start) begin
         r = '0;
         f = 1'b0;
         bpos_in = '0;
      end
      if (ctrl.scan_step && !found_ff) begin
         for (int i = 0; i < 32; i++) begin
            if (rd_data[i]) begin
               any = 1'b1;
               p = 5'(i);
            end
            len = any ? (BLK_W+1)'(i) - (BLK_W+1)'(p) : run_ff + (BLK_W+1)'(i + 1);
            if (!f && (len >= cnt_ff)) begin
               f = 1'b1;
               hit = 5'(i);
            end
         end
         r = len;
         if (f) begin
            s = bpos_ff + (BLK_W+1)'(hit) + 1'b1 - (BLK_W+1)'(cnt_ff);
         end
         bpos_in = bpos_ff + (BLK_W+1)'(32);
      end
      if (ctrl.mark_start) begin
         if (ctrl.mark_set) begin
            mfirst_in = start_ff;
            mend_in = start_ff + (BLK_W+1)'(cnt_ff);
         end else begin
            mfirst_in = (BLK_W+1)'(fstart);
            mend_in = (BLK_W+1)'(fend);
         end
         mword_in = mfirst_in[BLK_W:5];
      end
      if (ctrl.mark_step) begin
         mword_in = mword_ff + 1'b1;
         if (ctrl.mark_set) begin
            used_in = used_ff + (CNT_W)'(chg);
         end else begin
            used_in = used_ff - (CNT_W)'(chg);
         end
      end
      if (ctrl.finish) begin
         rstat_in = ctrl.res_status;
         if (req_command == CMD_ALLOC && ctrl.res_status == ST_OK) begin
            raddr_in = base_address + {(ADDR_W-BLOCK_SHIFT)'(start_ff), 12'd0};
         end else begin
            raddr_in = '0;
         end
      end
      run_in = r;
      found_in = f;
      start_in = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         found_ff <= found_in;
      end
      cnt_ff <= cnt_in;
      faddr_ff <= faddr_in;
      run_ff <= run_in;
      bpos_ff <= bpos_in;
      start_ff <= start_in;
      mfirst_ff <= mfirst_in;
      mend_ff <= mend_in;
      mword_ff <= mword_in;
      raddr_ff <= raddr_in;
      rstat_ff <= rstat_in;
   end

   assign stat.found = found_ff;
   assign stat.scan_last = (bpos_ff >= (BLK_W+1)'(NUM_BLOCKS));
   assign stat.mark_last = ({mword_ff, 5'd0} + (BLK_W+1)'(32)) >= mend_ff;
   assign stat.free_bad = ((ADDR_W+1)'(fstart) > NUM_BLOCKS_EXT) ||
                          (fend > NUM_BLOCKS_EXT);
   assign stat.cnt_zero = (cnt_ff == '0);
   assign stat.cnt_over = ((ADDR_W+1)'(cnt_ff) > NUM_BLOCKS_EXT);
   assign stat.mark_word = mword_ff[WIDX_W-1:0];

   assign res_address = raddr_ff;
   assign res_status = rstat_ff;
   assign res_used = used_ff;
endmodule

// File: hw/rtl/bffa_ctrl.sv
// Controller state machine of the block allocator.
module bffa_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_command,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  bffa_pkg::stat_type stat,
   output bffa_pkg::ctrl_type ctrl,
   output logic idle
);
   import bffa_pkg::*;
   `include "assert_macros.svh"

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_MARK_RD = 3'd3;
   localparam logic [2:0] S_MARK_WR = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [WIDX_W:0] raddr_ff, raddr_in;   // scan read pointer
   logic [1:0] cmd_ff, cmd_in;
   logic [1:0] stat_ff, stat_in;
   logic rvalid_ff, rvalid_in;             // scan read data valid next cycle

   always_comb begin
      state_in = state_ff;
      raddr_in = raddr_ff;
      cmd_in = cmd_ff;
      stat_in = stat_ff;
      rvalid_in = 1'b0;
      ctrl = '0;
      ctrl.mark_set = (cmd_ff == CMD_ALLOC);
      ctrl.res_status = stat_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               cmd_in = req_command;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            stat_in = ST_OK;
            state_in = S_DONE;
            if (cmd_ff == CMD_ALLOC) begin
               if (stat.cnt_zero || stat.cnt_over) begin
                  stat_in = ST_NO_SPACE;
               end else begin
                  ctrl.scan_start = 1'b1;
                  ctrl.rd_en = 1'b1;
                  ctrl.rd_addr = '0;
                  raddr_in = (WIDX_W+1)'(1);
                  rvalid_in = 1'b1;
                  state_in = S_SCAN;
               end
            end else if (cmd_ff == CMD_FREE) begin
               if (stat.free_bad) begin
                  stat_in = ST_BAD;
               end else if (!stat.cnt_zero) begin
                  ctrl.mark_start = 1'b1;
                  state_in = S_MARK_RD;
               end
            end else if (cmd_ff != CMD_REPORT) begin
               stat_in = ST_BAD;
            end
         end
         S_SCAN: begin
            ctrl.scan_step = rvalid_ff;
            if (stat.found) begin
               ctrl.mark_start = 1'b1;
               state_in = S_MARK_RD;
            end else if (stat.scan_last) begin
               stat_in = ST_NO_SPACE;
               state_in = S_DONE;
            end else if (raddr_ff < (WIDX_W+1)'(MAP_WORDS)) begin
               ctrl.rd_en = 1'b1;
               ctrl.rd_addr = raddr_ff[WIDX_W-1:0];
               raddr_in = raddr_ff + 1'b1;
               rvalid_in = 1'b1;
            end
         end
         S_MARK_RD: begin
            ctrl.rd_en = 1'b1;
            ctrl.rd_addr = stat.mark_word;
            state_in = S_MARK_WR;
         end
         S_MARK_WR: begin
            ctrl.mark_step = 1'b1;
            state_in = stat.mark_last ? S_DONE : S_MARK_RD;
         end
         S_DONE: begin
            ctrl.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rvalid_ff <= rvalid_in;
      end
      raddr_ff <= raddr_in;
      cmd_ff <= cmd_in;
      stat_ff <= stat_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign idle = (state_ff == S_IDLE);

   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall,
      state_ff == S_DECIDE)
   `ASSERT_IMPL(a_no_accept_while_busy, clock, reset, rsp_valid, req_stall)
   `ASSERT_IMPL(a_write_only_in_mark, clock, reset, ctrl.mark_step,
      state_ff == S_MARK_WR)
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid)
endmodule

// File: tb/bitmap_first_fit_block_allocator_tb.sv
// Self-checking testbench for the bitmap first-fit block allocator.
module bitmap_first_fit_block_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bffa_pkg::*;

   localparam int unsigned WATCHDOG_CYCLES = 20000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_command = CMD_REPORT;
   logic [12:0] req_block_count = '0;
   logic [31:0] req_free_address = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_result_address;
   logic [1:0] rsp_status;
   logic [12:0] rsp_used_blocks;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [31:0] csr_base_address = '0;

   typedef struct packed {
      logic [31:0] addr;
      logic [1:0] status;
      logic [12:0] used;
   } alloc_result_type;

   // Predictor state: one bit per block, the used count and the base register.
   logic [NUM_BLOCKS-1:0] model_map;
   logic [12:0] model_used;
   logic [31:0] model_base;
   alloc_result_type pending_results[$];
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   bit stall_bursty = 1'b0;

   // Addresses handed out by the allocator, kept for later frees.
   logic [31:0] live_addr[$];
   logic [12:0] live_cnt[$];

   bitmap_first_fit_block_allocator u_dut (.*);

   always #10 clock = ~clock;

   function automatic alloc_result_type predict_request(logic [1:0] cmd, logic [12:0] cnt,
                                                        logic [31:0] faddr);
      alloc_result_type res;
      int unsigned run;
      int start;
      logic [31:0] first;
      res = '{addr: '0, status: ST_OK, used: '0};
      if (cmd == CMD_ALLOC) begin
         start = -1;
         run = 0;
         if (cnt != 0 && cnt <= NUM_BLOCKS) begin
            for (int b = 0; b < NUM_BLOCKS; b++) begin
               if (model_map[b]) run = 0;
               else begin
                  run++;
                  if (run == cnt) begin
                     start = b + 1 - cnt;
                     break;
                  end
               end
            end
         end
         if (start < 0) res.status = ST_NO_SPACE;
         else begin
            for (int i = 0; i < cnt; i++) model_map[start+i] = 1'b1;
            model_used = model_used + 13'(cnt);
            res.addr = model_base + (32'(start) << BLOCK_SHIFT);
         end
      end else if (cmd == CMD_FREE) begin
         first = (faddr - model_base) >> BLOCK_SHIFT;
         if (first > NUM_BLOCKS || cnt > NUM_BLOCKS - first) res.status = ST_BAD;
         else begin
            for (int i = 0; i < cnt; i++) begin
               if (model_map[first+i]) begin
                  model_map[first+i] = 1'b0;
                  model_used = model_used - 13'd1;
               end
            end
         end
      end else if (cmd == CMD_UNUSED) begin
         res.status = ST_BAD;
      end
      res.used = model_used;
      return res;
   endfunction

   // Sends one request and queues its predicted result at acceptance.
   task automatic send_request(logic [1:0] cmd, logic [12:0] cnt, logic [31:0] faddr);
      alloc_result_type res;
      @(negedge clock);
      req_command <= cmd;
      req_block_count <= cnt;
      req_free_address <= faddr;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      res = predict_request(cmd, cnt, faddr);
      pending_results.push_back(res);
      if (cmd == CMD_ALLOC && res.status == ST_OK && live_addr.size() < 64) begin
         live_addr.push_back(res.addr);
         live_cnt.push_back(cnt);
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Random gap after some requests; mostly none.
   task automatic sender_gap();
      if ($urandom_range(3) == 0) repeat ($urandom_range(12)) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (450) @(negedge clock);
   endtask

   // The base register is written only once every request has been answered.
   task automatic write_base(logic [31:0] value);
      while (pending_results.size() != 0) @(negedge clock);
      csr_base_address <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      model_base = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [12:0] small_count();
      case ($urandom_range(9))
         0: return 13'($urandom_range(8191));
         1: return 13'($urandom_range(1024, 4096));
         default: return 13'($urandom_range(1, 40));
      endcase
   endfunction

   // Extremes of each field and every command, including the named special cases.
   task automatic test_directed();
      send_request(CMD_REPORT, 13'd0, 32'h0);
      send_request(CMD_ALLOC, 13'd0, 32'hFFFF_FFFF);
      send_request(CMD_ALLOC, 13'd4097, 32'h0);
      send_request(CMD_ALLOC, 13'h1FFF, 32'h0);
      send_request(CMD_ALLOC, 13'd1, 32'h0);
      send_request(CMD_ALLOC, 13'd31, 32'h0);
      send_request(CMD_ALLOC, 13'd33, 32'h0);
      send_request(CMD_FREE, 13'd1, model_base + 32'h1FFF);
      send_request(CMD_ALLOC, 13'd2, 32'h0);
      send_request(CMD_FREE, 13'd0, model_base);
      send_request(CMD_FREE, 13'd8, model_base + 32'h3_0000);
      send_request(CMD_FREE, 13'd1, model_base - 32'h1000);
      send_request(CMD_FREE, 13'd2, model_base + 32'h00FF_F000);
      send_request(CMD_FREE, 13'd0, model_base + 32'h0100_0000);
      send_request(CMD_FREE, 13'd4096, model_base);
      send_request(CMD_ALLOC, 13'd4096, 32'h0);
      send_request(CMD_ALLOC, 13'd1, 32'h0);
      send_request(CMD_FREE, 13'h1FFF, 32'hFFFF_FFFF);
      send_request(CMD_UNUSED, 13'h1FFF, 32'hFFFF_FFFF);
      send_request(CMD_FREE, 13'd4096, model_base);
      wait_drained();
   endtask

   // Register extremes with a short allocate and free sequence at each base.
   task automatic test_base_settings();
      logic [31:0] bases[4];
      bases = '{32'h0, 32'hFFFF_FFFF, 32'hAB00_0000, 32'h5555_5AAA};
      foreach (bases[k]) begin
         write_base(bases[k]);
         send_request(CMD_ALLOC, 13'd3, 32'h0);
         send_request(CMD_ALLOC, 13'd4090, 32'h0);
         send_request(CMD_FREE, 13'd4096, bases[k]);
         send_request(CMD_FREE, 13'd1, bases[k] - 32'h1);
      end
      wait_drained();
      write_base(BASE_RESET);
   endtask

   // Mostly alloc/free pairs on live runs, with noise and broken frees.
   task automatic test_random(int unsigned n);
      int unsigned sel;
      int unsigned k;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 45) send_request(CMD_ALLOC, small_count(), $urandom());
         else if (sel < 80 && live_addr.size() != 0) begin
            k = $urandom_range(live_addr.size() - 1);
            send_request(CMD_FREE, live_cnt[k] + 13'($urandom_range(1) * $urandom_range(3)),
                         live_addr[k] | 32'($urandom_range(4095)));
            live_addr.delete(k);
            live_cnt.delete(k);
         end else if (sel < 90) send_request(CMD_FREE, 13'($urandom()), $urandom());
         else send_request(2'($urandom_range(3)), 13'($urandom()), $urandom());
         if (i == n / 2) begin
            // Hold off until the allocator has answered everything so far.
            while (pending_results.size() != 0) @(negedge clock);
         end
         sender_gap();
      end
      wait_drained();
   endtask

   // Receiver stall pattern: alternating calm and bursty stretches.
   always @(negedge clock) begin
      if ($urandom_range(63) == 0) stall_bursty <= ~stall_bursty;
      rsp_stall <= stall_bursty ? ($urandom_range(2) != 0) : 1'b0;
   end

   // Checks each result transfer against the oldest prediction.
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result addr=%h status=%0d used=%0d", $realtime,
                     rsp_result_address, rsp_status, rsp_used_blocks);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_address !== want.addr) begin
               $display("%0t: result_address expected %h actual %h", $realtime,
                        want.addr, rsp_result_address);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        want.status, rsp_status);
               error_count++;
            end
            if (rsp_used_blocks !== want.used) begin
               $display("%0t: used_blocks expected %0d actual %0d", $realtime,
                        want.used, rsp_used_blocks);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("FAIL bitmap_first_fit_block_allocator");
         $finish;
      end
   end

   initial begin
      model_map = '0;
      model_used = '0;
      model_base = BASE_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_base_settings();
      test_random(520);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS bitmap_first_fit_block_allocator");
      end else begin
         $display("FAIL bitmap_first_fit_block_allocator");
      end
      $finish;
   end
endmodule
